// File: src/epsm_pkg.sv
// shared types, constants and helpers for the encoder period speed meter
`default_nettype none
package epsm_pkg;

  localparam int COUNT_W    = 16;
  localparam int SCALE_W    = 32;
  localparam int SPEED_W    = 32;
  localparam int WIN_W      = 16;
  localparam int CMP_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int DIV_BITS   = 2;
  localparam int DIV_STEPS  = SCALE_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1135514);
  localparam logic [WIN_W-1:0]   MIN_RESET   = WIN_W'(10);
  localparam logic [WIN_W-1:0]   MAX_RESET   = WIN_W'(65535);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_SCALE = 2'd0,
    REG_MIN_COUNT   = 2'd1,
    REG_MAX_COUNT   = 2'd2
  } epsm_reg_t;

  // latched channel state handed from front to back
  typedef struct packed {
    logic [COUNT_W-1:0] period_first;
    logic               reverse_first;
    logic [COUNT_W-1:0] period_second;
    logic               reverse_second;
  } epsm_entry_t;

  typedef struct packed {
    logic [SCALE_W-1:0] speed_scale;
    logic [WIN_W-1:0]   min_count;
    logic [WIN_W-1:0]   max_count;
  } epsm_cfg_t;

  // sign and saturate a quotient, zero when outside the window
  function automatic logic [SPEED_W-1:0] epsm_speed(input logic [SCALE_W-1:0] quot,
                                                    input logic reverse,
                                                    input logic in_win);
    logic [SPEED_W-1:0] mag;
    mag = '0;
    if (!in_win) begin
      return '0;
    end
    if (!reverse) begin
      mag = (quot > SCALE_W'(32'h7FFF_FFFF)) ? SPEED_W'(32'h7FFF_FFFF) : SPEED_W'(quot);
      return mag;
    end
    mag = (quot > SCALE_W'(32'h8000_0000)) ? SPEED_W'(32'h8000_0000) : SPEED_W'(quot);
    return SPEED_W'(0) - mag;
  endfunction

endpackage
`default_nettype wire

// File: src/epsm_front.sv
// front end: tick counters, period latches and direction per channel
`default_nettype none
module epsm_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_tick,
  input  wire logic                 in_edge_first,
  input  wire logic                 in_partner_first,
  input  wire logic                 in_edge_second,
  input  wire logic                 in_partner_second,
  input  wire logic                 fifo_full,
  output logic                      push,
  output epsm_pkg::epsm_entry_t     push_data
);
  import epsm_pkg::*;

  logic [COUNT_W-1:0] ticks_first_r, ticks_first_nxt;
  logic [COUNT_W-1:0] ticks_second_r, ticks_second_nxt;
  epsm_entry_t        ent_r, ent_nxt;
  logic               accept;

  assign in_stall = fifo_full;
  assign accept   = in_valid && !fifo_full;

  always_comb begin
    ticks_first_nxt  = ticks_first_r;
    ticks_second_nxt = ticks_second_r;
    ent_nxt          = ent_r;
    // tick first, saturating
    if (in_tick) begin
      if (ticks_first_r != COUNT_MAX) ticks_first_nxt = ticks_first_r + 1'b1;
      if (ticks_second_r != COUNT_MAX) ticks_second_nxt = ticks_second_r + 1'b1;
    end
    if (in_edge_first) begin
      ent_nxt.period_first  = ticks_first_nxt;
      ent_nxt.reverse_first = !in_partner_first;
      ticks_first_nxt       = '0;
    end
    if (in_edge_second) begin
      ent_nxt.period_second  = ticks_second_nxt;
      ent_nxt.reverse_second = !in_partner_second;
      ticks_second_nxt       = '0;
    end
  end

  assign push      = accept;
  assign push_data = ent_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_first_r  <= '0;
      ticks_second_r <= '0;
      ent_r          <= '0;
    end else if (accept) begin
      ticks_first_r  <= ticks_first_nxt;
      ticks_second_r <= ticks_second_nxt;
      ent_r          <= ent_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/epsm_fifo.sv
// short queue of latched channel state between front and back
`default_nettype none
module epsm_fifo (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire epsm_pkg::epsm_entry_t  push_data,
  input  wire logic                   pop,
  output epsm_pkg::epsm_entry_t       head,
  output logic                        full,
  output logic                        empty
);
  import epsm_pkg::*;

  epsm_entry_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0]     count_r;
  logic                      do_push, do_pop;

  assign full    = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: src/epsm_back.sv
// back end: shared iterative divider, sign and saturation, output register
`default_nettype none
module epsm_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire epsm_pkg::epsm_cfg_t     cfg,
  input  wire epsm_pkg::epsm_entry_t   head,
  input  wire logic                    fifo_empty,
  output logic                         pop,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [epsm_pkg::SPEED_W-1:0] out_speed_first,
  output logic signed [epsm_pkg::SPEED_W-1:0] out_speed_second
);
  import epsm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_WRITE
  } state_t;

  state_t               state_r;
  epsm_entry_t          ent_r;
  logic                 ch_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0]   div_r;
  logic [COUNT_W:0]     rem_r, rem_step;
  logic [SCALE_W-1:0]   dvd_r, dvd_step;
  logic [SPEED_W-1:0]   res_first_r, res_second_r;
  logic [SPEED_W-1:0]   out_first_r, out_second_r;
  logic                 out_valid_r;
  logic                 in_win;
  logic                 load_out;

  // two restoring steps per cycle, quotient bits shift into the dividend
  always_comb begin
    rem_step = rem_r;
    dvd_step = dvd_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem_step = {rem_step[COUNT_W-1:0], dvd_step[SCALE_W-1]};
      dvd_step = {dvd_step[SCALE_W-2:0], 1'b0};
      if (rem_step >= {1'b0, div_r}) begin
        rem_step    = rem_step - {1'b0, div_r};
        dvd_step[0] = 1'b1;
      end
    end
  end

  assign in_win = (CMP_W'(cfg.min_count) < CMP_W'(div_r)) &&
                  (CMP_W'(div_r) < CMP_W'(cfg.max_count));

  // output register takes a new pair when empty or being drained this cycle
  assign load_out         = (state_r == S_WRITE) && (!out_valid_r || !out_stall);
  assign pop              = (state_r == S_IDLE) && !fifo_empty;
  assign out_valid        = out_valid_r;
  assign out_speed_first  = $signed(out_first_r);
  assign out_speed_second = $signed(out_second_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ch_r        <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!fifo_empty) begin
            ent_r   <= head;
            div_r   <= head.period_first;
            rem_r   <= '0;
            dvd_r   <= cfg.speed_scale;
            cnt_r   <= '0;
            ch_r    <= 1'b0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= rem_step;
          dvd_r <= dvd_step;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
            cnt_r <= '0;
            if (!ch_r) begin
              res_first_r <= epsm_speed(dvd_step, ent_r.reverse_first, in_win);
              div_r       <= ent_r.period_second;
              rem_r       <= '0;
              dvd_r       <= cfg.speed_scale;
              ch_r        <= 1'b1;
            end else begin
              res_second_r <= epsm_speed(dvd_step, ent_r.reverse_second, in_win);
              state_r      <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          if (load_out) begin
            out_first_r  <= res_first_r;
            out_second_r <= res_second_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/encoder_period_speed_meter_unit.sv
// top level of the two-channel encoder period speed meter
`default_nettype none
// Two-channel encoder speed meter by period measurement. Each input transaction
// may carry a timer tick (both 16-bit saturating tick counters count up) and a
// rising phase A edge per channel with the phase B level; on an edge the tick
// is applied first, the count is latched as the period, the counter clears and
// phase B gives the direction (1 = forward). Every input transaction yields one
// output transaction with both signed Q23.8 speeds: speed_scale / period,
// truncated, negated in reverse and saturated to 32 bits, or 0 unless
// min_count < period < max_count. The front end takes a transaction whenever the
// queue has room and queues the latched state (two entries); the back end runs
// both divisions in turn on one shared radix-4 restoring divider and then loads
// the pair into the output register, popping the next entry only once back in
// idle. The user must write the config port (0 speed_scale, 1 min_count,
// 2 max_count) only while idle; the block itself does not enforce this.
module encoder_period_speed_meter_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // config write port
  input  wire logic                                 cfg_we,
  input  wire logic [epsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [epsm_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_tick,
  input  wire logic                                 in_edge_first,
  input  wire logic                                 in_partner_first,
  input  wire logic                                 in_edge_second,
  input  wire logic                                 in_partner_second,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [epsm_pkg::SPEED_W-1:0]       out_speed_first,
  output logic signed [epsm_pkg::SPEED_W-1:0]       out_speed_second
);
  import epsm_pkg::*;

  epsm_cfg_t   cfg_r;
  epsm_entry_t push_data, head;
  logic        push, pop, fifo_full, fifo_empty;

  // config registers, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_scale <= SCALE_RESET;
      cfg_r.min_count   <= MIN_RESET;
      cfg_r.max_count   <= MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPEED_SCALE: cfg_r.speed_scale <= SCALE_W'(cfg_data);
        REG_MIN_COUNT:   cfg_r.min_count   <= cfg_data[WIN_W-1:0];
        REG_MAX_COUNT:   cfg_r.max_count   <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: counters and latches, one transaction per cycle while queue has room
  epsm_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_tick           (in_tick),
    .in_edge_first     (in_edge_first),
    .in_partner_first  (in_partner_first),
    .in_edge_second    (in_edge_second),
    .in_partner_second (in_partner_second),
    .fifo_full         (fifo_full),
    .push              (push),
    .push_data         (push_data)
  );

  // decouples the front end from the divider
  epsm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  // back end: divider, sign, saturation and output register
  epsm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .head             (head),
    .fifo_empty       (fifo_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_speed_first  (out_speed_first),
    .out_speed_second (out_speed_second)
  );

endmodule
`default_nettype wire
